### src/sdis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdis_pkg
// Request and result formats, command codes and status codes of the SD/MMC
// card identification sequencer.
// ----------------------------------------------------------------------------
package sdis_pkg;

    // request kinds
    localparam logic OP_START    = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    // response status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;

    // final error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NO_CARD   = 2'd1;
    localparam logic [1:0] ERR_NO_RESP   = 2'd2;
    localparam logic [1:0] ERR_CARD_FAIL = 2'd3;

    // card types
    localparam logic [1:0] CARD_UNKNOWN = 2'd0;
    localparam logic [1:0] CARD_SDV1    = 2'd1;
    localparam logic [1:0] CARD_SDV2    = 2'd2;
    localparam logic [1:0] CARD_MMC     = 2'd3;

    // command indexes
    localparam logic [5:0] CMD_GO_IDLE       = 6'd0;
    localparam logic [5:0] CMD_SEND_OP_MMC   = 6'd1;
    localparam logic [5:0] CMD_ALL_SEND_CID  = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA      = 6'd3;
    localparam logic [5:0] ACMD_SET_BUS      = 6'd6;
    localparam logic [5:0] CMD_SELECT        = 6'd7;
    localparam logic [5:0] CMD_SEND_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD      = 6'd9;
    localparam logic [5:0] ACMD_SD_SEND_OP   = 6'd41;
    localparam logic [5:0] CMD_APP_CMD       = 6'd55;

    // command arguments
    localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
    localparam logic [31:0] ARG_SD_OCR    = 32'h50FF_8000;
    localparam logic [31:0] ARG_MMC_OCR   = 32'h00FF_8000;
    localparam logic [31:0] ARG_MMC_RCA   = 32'h0001_0000;
    localparam logic [31:0] ARG_BUS_4BIT  = 32'h0000_0002;

    typedef struct packed {
        logic        op;
        logic        card_present;
        logic [1:0]  resp_status;
        logic [31:0] resp_word;
    } sdis_req_t;

    typedef struct packed {
        logic        send_cmd;
        logic [5:0]  cmd_index;
        logic        app_command;
        logic [31:0] cmd_arg;
        logic        reset_cmd_line;
        logic        slow_clock;
        logic        finished;
        logic [1:0]  error_code;
        logic [1:0]  card_type;
        logic        block_addressing;
        logic [15:0] card_rca;
        logic        wide_bus;
    } sdis_rsp_t;

    function automatic sdis_rsp_t make_cmd(input logic [5:0] idx, input logic app,
                                           input logic [31:0] arg, input logic rst,
                                           input logic slow);
        sdis_rsp_t r;
        r                = '0;
        r.send_cmd       = 1'b1;
        r.cmd_index      = idx;
        r.app_command    = app;
        r.cmd_arg        = arg;
        r.reset_cmd_line = rst;
        r.slow_clock     = slow;
        return r;
    endfunction

    function automatic sdis_rsp_t make_fail(input logic [1:0] err, input logic rst);
        sdis_rsp_t r;
        r                = '0;
        r.reset_cmd_line = rst;
        r.finished       = 1'b1;
        r.error_code     = err;
        return r;
    endfunction

endpackage

### src/sdis_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdis_if
// Valid/ready channels for sequencer requests and results.
// ----------------------------------------------------------------------------
interface sdis_req_if import sdis_pkg::*; ();
    logic      valid;
    logic      ready;
    sdis_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sdis_rsp_if import sdis_pkg::*; ();
    logic      valid;
    logic      ready;
    sdis_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/sd_card_init_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_card_init_sequencer
// A result is registered and valid on the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register is refilled
// in the same cycle it is taken, so only a stalled result holds off requests.
// Reset: phase idle, card flags and RCA cleared, no result pending.
// Host-side SD/MMC identification: issues the next command per response.
// ----------------------------------------------------------------------------
module sd_card_init_sequencer
    import sdis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sdis_req_if.sink          req,
    sdis_rsp_if.source        rsp
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CMD0,
        PH_CMD8,
        PH_APP41,
        PH_ACMD41,
        PH_CMD1,
        PH_CMD2,
        PH_CMD3,
        PH_CMD9,
        PH_CMD7,
        PH_APP6,
        PH_ACMD6,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        v2_reg, v2_next;
    logic        mmc_reg, mmc_next;
    logic        ccs_reg, ccs_next;
    logic [15:0] rca_reg, rca_next;
    logic        out_valid_reg;
    sdis_rsp_t   out_data_reg, out_data_next;
    logic        emit;

    logic        in_fire;
    logic        st_ok;
    logic [1:0]  err_code;
    logic        is_mmc;
    logic [1:0]  type_cur;
    logic        busy;
    sdis_rsp_t   ok_result;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign in_fire   = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign st_ok    = (req.data.resp_status == ST_OK);
    assign err_code = (req.data.resp_status == ST_TIMEOUT) ? ERR_NO_RESP : ERR_CARD_FAIL;
    assign is_mmc   = !v2_reg && mmc_reg;
    assign type_cur = v2_reg ? CARD_SDV2 : (mmc_reg ? CARD_MMC : CARD_SDV1);
    assign busy     = req.data.resp_word[31];

    always_comb
    begin
        ok_result                  = '0;
        ok_result.finished         = 1'b1;
        ok_result.error_code       = ERR_NONE;
        ok_result.card_type        = type_cur;
        ok_result.block_addressing = v2_reg && ccs_reg;
        ok_result.card_rca         = rca_reg;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        v2_next       = v2_reg;
        mmc_next      = mmc_reg;
        ccs_next      = ccs_reg;
        rca_next      = rca_reg;
        out_data_next = '0;
        emit          = 1'b1;

        if (req.data.op == OP_START)
        begin
            // restart clears every flag
            v2_next  = 1'b0;
            mmc_next = 1'b0;
            ccs_next = 1'b0;
            rca_next = '0;
            if (!req.data.card_present)
            begin
                out_data_next = make_fail(ERR_NO_CARD, 1'b0);
                phase_next    = PH_DONE;
            end
            else
            begin
                out_data_next = make_cmd(CMD_GO_IDLE, 1'b0, '0, 1'b0, 1'b0);
                phase_next    = PH_CMD0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_CMD0:
                begin
                    if (!st_ok)
                    begin
                        out_data_next = make_fail(err_code, 1'b0);
                        phase_next    = PH_DONE;
                    end
                    else
                    begin
                        out_data_next = make_cmd(CMD_SEND_IF_COND, 1'b0, ARG_IF_COND,
                                                 1'b0, 1'b0);
                        phase_next    = PH_CMD8;
                    end
                end
                PH_CMD8:
                begin
                    if (st_ok || req.data.resp_status == ST_TIMEOUT)
                    begin
                        // a timeout means a v1 card: reset the line and go on
                        v2_next       = st_ok;
                        out_data_next = make_cmd(CMD_APP_CMD, 1'b0, '0, !st_ok, 1'b0);
                        phase_next    = PH_APP41;
                    end
                    else
                    begin
                        out_data_next = make_fail(ERR_CARD_FAIL, 1'b0);
                        phase_next    = PH_DONE;
                    end
                end
                PH_APP41, PH_ACMD41:
                begin
                    if (!st_ok)
                    begin
                        // fall back to MMC at the slow clock
                        out_data_next = make_cmd(CMD_SEND_OP_MMC, 1'b0, ARG_MMC_OCR,
                                                 1'b1, 1'b1);
                        phase_next    = PH_CMD1;
                    end
                    else if (phase_reg == PH_APP41)
                    begin
                        out_data_next = make_cmd(ACMD_SD_SEND_OP, 1'b1, ARG_SD_OCR,
                                                 1'b0, 1'b0);
                        phase_next    = PH_ACMD41;
                    end
                    else if (busy)
                    begin
                        ccs_next      = req.data.resp_word[30];
                        out_data_next = make_cmd(CMD_ALL_SEND_CID, 1'b0, '0, 1'b0, 1'b0);
                        phase_next    = PH_CMD2;
                    end
                    else
                    begin
                        out_data_next = make_cmd(CMD_APP_CMD, 1'b0, '0, 1'b0, 1'b0);
                        phase_next    = PH_APP41;
                    end
                end
                PH_CMD1:
                begin
                    if (!st_ok)
                    begin
                        out_data_next = make_fail(ERR_NO_RESP, 1'b1);
                        phase_next    = PH_DONE;
                    end
                    else if (busy)
                    begin
                        mmc_next      = 1'b1;
                        out_data_next = make_cmd(CMD_ALL_SEND_CID, 1'b0, '0, 1'b0, 1'b0);
                        phase_next    = PH_CMD2;
                    end
                    else
                    begin
                        out_data_next = make_cmd(CMD_SEND_OP_MMC, 1'b0, ARG_MMC_OCR,
                                                 1'b0, 1'b0);
                    end
                end
                PH_CMD2:
                begin
                    out_data_next = make_cmd(CMD_SEND_RCA, 1'b0,
                                             is_mmc ? ARG_MMC_RCA : '0, !st_ok, 1'b0);
                    phase_next    = PH_CMD3;
                end
                PH_CMD3:
                begin
                    if (st_ok)
                    begin
                        rca_next = is_mmc ? 16'd1 : req.data.resp_word[31:16];
                    end
                    out_data_next = make_cmd(CMD_SEND_CSD, 1'b0, {rca_next, 16'h0000},
                                             !st_ok, 1'b0);
                    phase_next    = PH_CMD9;
                end
                PH_CMD9:
                begin
                    if (rca_reg == '0)
                    begin
                        // nothing to select: finish as is
                        out_data_next                = ok_result;
                        out_data_next.reset_cmd_line = !st_ok;
                        phase_next                   = PH_DONE;
                    end
                    else
                    begin
                        out_data_next = make_cmd(CMD_SELECT, 1'b0, {rca_reg, 16'h0000},
                                                 !st_ok, 1'b0);
                        phase_next    = PH_CMD7;
                    end
                end
                PH_CMD7:
                begin
                    if (!st_ok)
                    begin
                        out_data_next = make_fail(err_code, 1'b0);
                        phase_next    = PH_DONE;
                    end
                    else
                    begin
                        out_data_next = make_cmd(CMD_APP_CMD, 1'b0, {rca_reg, 16'h0000},
                                                 1'b0, 1'b0);
                        phase_next    = PH_APP6;
                    end
                end
                PH_APP6:
                begin
                    if (!st_ok)
                    begin
                        out_data_next = ok_result;
                        phase_next    = PH_DONE;
                    end
                    else
                    begin
                        out_data_next = make_cmd(ACMD_SET_BUS, 1'b1, ARG_BUS_4BIT,
                                                 1'b0, 1'b0);
                        phase_next    = PH_ACMD6;
                    end
                end
                PH_ACMD6:
                begin
                    out_data_next          = ok_result;
                    out_data_next.wide_bus = st_ok;
                    phase_next             = PH_DONE;
                end
                default:
                begin
                    // idle or finished: drop the response
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            v2_reg        <= 1'b0;
            mmc_reg       <= 1'b0;
            ccs_reg       <= 1'b0;
            rca_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg <= phase_next;
                v2_reg    <= v2_next;
                mmc_reg   <= mmc_next;
                ccs_reg   <= ccs_next;
                rca_reg   <= rca_next;
            end
            if (in_fire && emit)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_cmd_xor_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.send_cmd != out_data_reg.finished))
        else $error("result must be either a command or a finish");

    a_no_card: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req.data.op == OP_START && !req.data.card_present) |=>
        (out_valid_reg && out_data_reg.finished && out_data_reg.error_code == ERR_NO_CARD))
        else $error("missing card did not finish with no-card status");

    a_block_addr_v2: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.block_addressing) |->
        (out_data_reg.card_type == CARD_SDV2))
        else $error("block addressing reported on a card that is not SD v2");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req.data.op == OP_RESPONSE &&
         (phase_reg == PH_DONE || phase_reg == PH_IDLE)) |=> (phase_reg == $past(phase_reg)))
        else $error("ignored response changed the phase");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
        else $error("request stalled with the result register empty");

endmodule

### tb/tb_sd_card_init_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sd_card_init_sequencer
// Self-checking bench for the SD/MMC identification sequencer. Directed
// tests walk the SD v2, MMC fallback, no-card and error paths; a random phase
// then runs mostly complete identification sequences with random responses,
// restarts and stray responses. A local model of the sequence predicts each
// result, and the results are checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_sd_card_init_sequencer
    import sdis_pkg::*;
();

    // status codes the package leaves unnamed
    localparam logic [1:0] ST_ERROR     = 2'd2;
    localparam logic [1:0] ST_UNDEFINED = 2'd3;

    localparam int RANDOM_RESULTS = 2000;
    localparam int STEADY_FIRST   = 800;
    localparam int STEADY_LAST    = 1100;
    localparam int MAX_PRINTS     = 30;

    typedef enum logic [3:0] {
        S_IDLE, S_GO_IDLE, S_IF_COND, S_APP41, S_OP_COND, S_MMC_OP, S_CID,
        S_RCA, S_CSD, S_SELECT, S_APP6, S_BUS, S_DONE
    } seq_phase_e;

    logic clk;
    logic rst_n;

    sdis_req_if req_if ();
    sdis_rsp_if rsp_if ();

    sd_card_init_sequencer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // model of the card sequence
    seq_phase_e  phase;
    logic        v2_flag;
    logic        mmc_flag;
    logic        ccs_flag;
    logic [15:0] rca;

    sdis_rsp_t step_outputs[$];

    bit steady;
    bit last_had_result;
    int mismatches;
    int requests_sent;
    int requests_ignored;
    int results_checked;
    int seq_ok;
    int seq_failed;
    int seq_wide;
    int seq_mmc;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report(input string msg);
        if (mismatches < MAX_PRINTS)
        begin
            $display("%0t ns MISMATCH: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic logic [1:0] card_kind();
        if (v2_flag)
        begin
            return CARD_SDV2;
        end
        if (mmc_flag)
        begin
            return CARD_MMC;
        end
        return CARD_SDV1;
    endfunction

    function automatic sdis_rsp_t issue(input logic [5:0] idx, input logic app,
                                        input logic [31:0] arg, input logic rst,
                                        input logic slow);
        sdis_rsp_t o;
        o                = '0;
        o.send_cmd       = 1'b1;
        o.cmd_index      = idx;
        o.app_command    = app;
        o.cmd_arg        = arg;
        o.reset_cmd_line = rst;
        o.slow_clock     = slow;
        return o;
    endfunction

    function automatic sdis_rsp_t abort_with(input logic [1:0] err, input logic rst);
        sdis_rsp_t o;
        o                = '0;
        o.reset_cmd_line = rst;
        o.finished       = 1'b1;
        o.error_code     = err;
        phase            = S_DONE;
        seq_failed++;
        return o;
    endfunction

    function automatic sdis_rsp_t complete_with(input logic wide);
        sdis_rsp_t o;
        o                  = '0;
        o.finished         = 1'b1;
        o.error_code       = ERR_NONE;
        o.card_type        = card_kind();
        o.block_addressing = v2_flag & ccs_flag;
        o.card_rca         = rca;
        o.wide_bus         = wide;
        phase              = S_DONE;
        seq_ok++;
        if (wide)
        begin
            seq_wide++;
        end
        if (o.card_type == CARD_MMC)
        begin
            seq_mmc++;
        end
        return o;
    endfunction

    function automatic logic [1:0] error_of(input logic [1:0] status);
        return (status == ST_TIMEOUT) ? ERR_NO_RESP : ERR_CARD_FAIL;
    endfunction

    // Advance the sequence by one request; returns 0 when the block stays silent.
    function automatic bit advance_sequence(input sdis_req_t r, output sdis_rsp_t o);
        logic ok;
        logic busy;
        ok   = (r.resp_status == ST_OK);
        busy = r.resp_word[31];
        o    = '0;
        if (r.op == OP_START)
        begin
            v2_flag  = 1'b0;
            mmc_flag = 1'b0;
            ccs_flag = 1'b0;
            rca      = '0;
            if (!r.card_present)
            begin
                o = abort_with(ERR_NO_CARD, 1'b0);
            end
            else
            begin
                o     = issue(CMD_GO_IDLE, 1'b0, '0, 1'b0, 1'b0);
                phase = S_GO_IDLE;
            end
            return 1'b1;
        end
        case (phase)
            S_GO_IDLE:
            begin
                if (!ok)
                begin
                    o = abort_with(error_of(r.resp_status), 1'b0);
                end
                else
                begin
                    o     = issue(CMD_SEND_IF_COND, 1'b0, ARG_IF_COND, 1'b0, 1'b0);
                    phase = S_IF_COND;
                end
            end
            S_IF_COND:
            begin
                if (ok)
                begin
                    v2_flag = 1'b1;
                    o       = issue(CMD_APP_CMD, 1'b0, '0, 1'b0, 1'b0);
                    phase   = S_APP41;
                end
                else if (r.resp_status == ST_TIMEOUT)
                begin
                    // no answer to CMD8: treat as a v1 card
                    o     = issue(CMD_APP_CMD, 1'b0, '0, 1'b1, 1'b0);
                    phase = S_APP41;
                end
                else
                begin
                    o = abort_with(ERR_CARD_FAIL, 1'b0);
                end
            end
            S_APP41, S_OP_COND:
            begin
                if (!ok)
                begin
                    // drop to the MMC loop at the slow clock
                    o     = issue(CMD_SEND_OP_MMC, 1'b0, ARG_MMC_OCR, 1'b1, 1'b1);
                    phase = S_MMC_OP;
                end
                else if (phase == S_APP41)
                begin
                    o     = issue(ACMD_SD_SEND_OP, 1'b1, ARG_SD_OCR, 1'b0, 1'b0);
                    phase = S_OP_COND;
                end
                else if (busy)
                begin
                    ccs_flag = r.resp_word[30];
                    o        = issue(CMD_ALL_SEND_CID, 1'b0, '0, 1'b0, 1'b0);
                    phase    = S_CID;
                end
                else
                begin
                    o     = issue(CMD_APP_CMD, 1'b0, '0, 1'b0, 1'b0);
                    phase = S_APP41;
                end
            end
            S_MMC_OP:
            begin
                if (!ok)
                begin
                    o = abort_with(ERR_NO_RESP, 1'b1);
                end
                else if (busy)
                begin
                    mmc_flag = 1'b1;
                    o        = issue(CMD_ALL_SEND_CID, 1'b0, '0, 1'b0, 1'b0);
                    phase    = S_CID;
                end
                else
                begin
                    o = issue(CMD_SEND_OP_MMC, 1'b0, ARG_MMC_OCR, 1'b0, 1'b0);
                end
            end
            S_CID:
            begin
                o     = issue(CMD_SEND_RCA, 1'b0,
                              (card_kind() == CARD_MMC) ? ARG_MMC_RCA : 32'h0, !ok, 1'b0);
                phase = S_RCA;
            end
            S_RCA:
            begin
                if (ok)
                begin
                    rca = (card_kind() == CARD_MMC) ? 16'd1 : r.resp_word[31:16];
                end
                o     = issue(CMD_SEND_CSD, 1'b0, {rca, 16'h0}, !ok, 1'b0);
                phase = S_CSD;
            end
            S_CSD:
            begin
                if (rca == '0)
                begin
                    o                = complete_with(1'b0);
                    o.reset_cmd_line = !ok;
                end
                else
                begin
                    o     = issue(CMD_SELECT, 1'b0, {rca, 16'h0}, !ok, 1'b0);
                    phase = S_SELECT;
                end
            end
            S_SELECT:
            begin
                if (!ok)
                begin
                    o = abort_with(error_of(r.resp_status), 1'b0);
                end
                else
                begin
                    o     = issue(CMD_APP_CMD, 1'b0, {rca, 16'h0}, 1'b0, 1'b0);
                    phase = S_APP6;
                end
            end
            S_APP6:
            begin
                if (!ok)
                begin
                    o = complete_with(1'b0);
                end
                else
                begin
                    o     = issue(ACMD_SET_BUS, 1'b1, ARG_BUS_4BIT, 1'b0, 1'b0);
                    phase = S_BUS;
                end
            end
            S_BUS:
            begin
                o = complete_with(ok);
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    task automatic send_req(input logic op, input logic present,
                            input logic [1:0] status, input logic [31:0] word);
        sdis_req_t r;
        sdis_rsp_t o;
        r.op           = op;
        r.card_present = present;
        r.resp_status  = status;
        r.resp_word    = word;
        if (!steady && $urandom_range(99) < 22)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_if.data  <= r;
        req_if.valid <= 1'b1;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
        last_had_result = advance_sequence(r, o);
        if (last_had_result)
        begin
            step_outputs.push_back(o);
        end
        else
        begin
            requests_ignored++;
        end
    endtask

    // start and answer fill the fields the block does not look at with noise
    task automatic start_seq(input logic present);
        send_req(OP_START, present, 2'($urandom), $urandom);
    endtask

    task automatic answer(input logic [1:0] status, input logic [31:0] word);
        send_req(OP_RESPONSE, 1'($urandom), status, word);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            report($sformatf("result %0d %s: got %0h, want %0h",
                             results_checked, name, got, want));
        end
    endtask

    task automatic check_result(input sdis_rsp_t got);
        sdis_rsp_t want;
        if (step_outputs.size() == 0)
        begin
            report($sformatf("result %0d arrived with no request waiting",
                             results_checked));
            results_checked++;
            return;
        end
        want = step_outputs.pop_front();
        compare_field("send_cmd", 32'(got.send_cmd), 32'(want.send_cmd));
        compare_field("cmd_index", 32'(got.cmd_index), 32'(want.cmd_index));
        compare_field("app_command", 32'(got.app_command), 32'(want.app_command));
        compare_field("cmd_arg", got.cmd_arg, want.cmd_arg);
        compare_field("reset_cmd_line", 32'(got.reset_cmd_line),
                      32'(want.reset_cmd_line));
        compare_field("slow_clock", 32'(got.slow_clock), 32'(want.slow_clock));
        compare_field("finished", 32'(got.finished), 32'(want.finished));
        compare_field("error_code", 32'(got.error_code), 32'(want.error_code));
        compare_field("card_type", 32'(got.card_type), 32'(want.card_type));
        compare_field("block_addressing", 32'(got.block_addressing),
                      32'(want.block_addressing));
        compare_field("card_rca", 32'(got.card_rca), 32'(want.card_rca));
        compare_field("wide_bus", 32'(got.wide_bus), 32'(want.wide_bus));
        results_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                check_result(rsp_if.data);
            end
            rsp_if.ready <= steady || ($urandom_range(99) >= 22);
        end
        else
        begin
            rsp_if.ready <= 1'b0;
        end
    end

    task automatic test_ignored_and_no_card();
        answer(ST_OK, 32'h0);
        start_seq(1'b0);
        answer(ST_TIMEOUT, 32'hFFFF_FFFF);
    endtask

    task automatic test_go_idle_error();
        start_seq(1'b1);
        answer(ST_UNDEFINED, 32'h0);
    endtask

    task automatic test_if_cond_error();
        start_seq(1'b1);
        answer(ST_OK, $urandom);
        answer(ST_ERROR, $urandom);
    endtask

    task automatic test_mmc_fallback();
        start_seq(1'b1);
        answer(ST_OK, 32'h0);
        answer(ST_TIMEOUT, 32'h0);
        answer(ST_TIMEOUT, 32'h0);
        answer(ST_OK, 32'h0);
        answer(ST_OK, 32'h8000_0000);
        answer(ST_ERROR, 32'h0);
        answer(ST_OK, 32'h1234_5678);
        answer(ST_OK, 32'h0);
        answer(ST_OK, 32'h0);
        answer(ST_OK, 32'h0);
        answer(ST_OK, 32'h0);
    endtask

    task automatic test_sd_v2_zero_rca();
        start_seq(1'b1);
        answer(ST_OK, 32'h0);
        answer(ST_OK, 32'h0);
        answer(ST_OK, 32'h0);
        answer(ST_OK, 32'h0);
        answer(ST_OK, 32'h0);
        answer(ST_OK, 32'hFFFF_FFFF);
        answer(ST_OK, 32'h0);
        answer(ST_OK, 32'h0000_FFFF);
        answer(ST_TIMEOUT, 32'hFFFF_FFFF);
    endtask

    // Mostly whole sequences with random answers, plus restarts and stray answers.
    task automatic test_random_traffic(input int target);
        int produced;
        int pick;
        logic [1:0] status;
        logic [31:0] word;
        produced = 0;
        while (produced < target)
        begin
            steady = (produced >= STEADY_FIRST) && (produced < STEADY_LAST);
            pick   = $urandom_range(99);
            word   = $urandom;
            if ($urandom_range(9) == 0)
            begin
                word[31:16] = '0;
            end
            pick   = $urandom_range(99);
            status = (pick < 80) ? ST_OK : (pick < 88) ? ST_TIMEOUT :
                     (pick < 94) ? ST_ERROR : ST_UNDEFINED;
            pick   = $urandom_range(99);
            if (phase == S_IDLE || phase == S_DONE)
            begin
                if (pick < 15)
                begin
                    answer(2'($urandom), word);
                end
                else
                begin
                    start_seq($urandom_range(9) != 0);
                end
            end
            else if (pick < 3)
            begin
                start_seq(1'($urandom));
            end
            else
            begin
                answer(status, word);
            end
            if (last_had_result)
            begin
                produced++;
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        rst_n         <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.data   <= '0;
        phase    = S_IDLE;
        v2_flag  = 1'b0;
        mmc_flag = 1'b0;
        ccs_flag = 1'b0;
        rca      = '0;
        steady   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_and_no_card();
        test_go_idle_error();
        test_if_cond_error();
        test_mmc_fallback();
        test_sd_v2_zero_rca();
        test_random_traffic(RANDOM_RESULTS);
        req_if.valid <= 1'b0;

        while (step_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d requests (%0d ignored), checked %0d results.",
                 requests_sent, requests_ignored, results_checked);
        $display("Sequences: %0d completed (%0d MMC, %0d 4-bit), %0d aborted.",
                 seq_ok, seq_mmc, seq_wide, seq_failed);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
